// ===== rtl/core/sti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants of the sorted table
// holds table sizing, transaction payloads, codes and the memory request
// ----------------------------------------------------------------------------
package sti_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STAT_INSERTED  = 2'd0,
        STAT_REMOVED   = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        SEQ_IDLE,
        SEQ_INS,
        SEQ_INS_LAST,
        SEQ_REM,
        SEQ_FIN
    } seq_state_t;

    typedef struct packed
    {
        logic        opcode;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed
    {
        logic [1:0]  status;
        logic [6:0]  entry_count;
        logic [31:0] smallest_value;
    } rsp_t;

    typedef struct packed
    {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic                   re;
        logic [IDX_W-1:0]       raddr;
    } ram_req_t;

endpackage : sti_pkg
`default_nettype wire

// ===== rtl/core/sorted_table_insert_remove.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_insert_remove: ascending multiset with insert and remove
// a result reaches the output register from the finish state, after the
//   one-entry-per-cycle memory walk; it waits there while the output stalls
// a new command is taken only back in idle, after the last result has been
//   handed on; an insert that lands at the bottom entry takes one extra step
// reset: table empty at once, no clearing pass; memory contents undefined
// ----------------------------------------------------------------------------
module sorted_table_insert_remove
import sti_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output      logic cmd_stall,
    input  wire cmd_t cmd,
    output      logic rsp_valid,
    input  wire logic rsp_stall,
    output      rsp_t rsp
);

    // memory request from the sequencer: one write and one read per cycle
    ram_req_t               ram_req;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    // finished result handed to the output register
    logic res_valid;
    logic res_ready;
    rsp_t res;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    // table storage, entries below the held count are live
    sti_ram
    #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // insert walks down shifting entries up, remove walks up closing the gap;
    // the write and read addresses stay two apart so no forwarding is needed
    sti_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: next command runs while the last result waits
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule : sorted_table_insert_remove
`default_nettype wire

// ===== rtl/core/sti_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sti_ram: generic simple dual port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module sti_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : sti_ram
`default_nettype wire

// ===== rtl/core/sti_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sti_seq: table sequencer
// walks the table memory one entry a cycle to insert or remove a value
// ----------------------------------------------------------------------------
module sti_seq
import sti_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output      logic                   cmd_stall,
    input  wire cmd_t                   cmd,
    output      ram_req_t               ram_req,
    input  wire logic [VALUE_WIDTH-1:0] ram_rdata,
    output      logic                   res_valid,
    input  wire logic                   res_ready,
    output      rsp_t                   res
);

    seq_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] head_reg, head_next;
    logic [IDX_W-1:0]       dx_reg, dx_next;
    logic                   found_reg, found_next;
    status_t                status_reg, status_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                   last_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            cnt_reg    <= '0;
            head_reg   <= '0;
            dx_reg     <= '0;
            found_reg  <= 1'b0;
            status_reg <= STAT_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            head_reg   <= head_next;
            dx_reg     <= dx_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // data arriving now belongs to the top entry in use
    assign last_idx = (CNT_W'(dx_reg) == (cnt_reg - CNT_W'(1)));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        head_next   = head_reg;
        dx_next     = dx_reg;
        found_next  = found_reg;
        status_next = status_reg;
        val_next    = val_reg;
        ram_req     = '0;
        cmd_stall   = 1'b1;
        res_valid   = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    val_next = VALUE_WIDTH'(cmd.value);
                    if (cmd.opcode == OP_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                            state_next  = SEQ_FIN;
                        end
                        else if (cnt_reg == '0)
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = '0;
                            ram_req.wdata = VALUE_WIDTH'(cmd.value);
                            head_next     = VALUE_WIDTH'(cmd.value);
                            cnt_next      = CNT_W'(1);
                            status_next   = STAT_INSERTED;
                            state_next    = SEQ_FIN;
                        end
                        else
                        begin
                            // walk down from the top entry
                            ram_req.re    = 1'b1;
                            ram_req.raddr = IDX_W'(cnt_reg - CNT_W'(1));
                            dx_next       = IDX_W'(cnt_reg - CNT_W'(1));
                            state_next    = SEQ_INS;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = STAT_NOT_FOUND;
                            state_next  = SEQ_FIN;
                        end
                        else
                        begin
                            // walk up from the bottom entry
                            ram_req.re    = 1'b1;
                            ram_req.raddr = '0;
                            dx_next       = '0;
                            found_next    = 1'b0;
                            state_next    = SEQ_REM;
                        end
                    end
                end
            end

            SEQ_INS:
            begin
                // write goes one above, read one below: never the same entry
                ram_req.we    = 1'b1;
                ram_req.waddr = IDX_W'(dx_reg + IDX_W'(1));
                if (ram_rdata >= val_reg)
                begin
                    ram_req.wdata = ram_rdata;
                    if (dx_reg == '0)
                    begin
                        state_next = SEQ_INS_LAST;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = IDX_W'(dx_reg - IDX_W'(1));
                        dx_next       = IDX_W'(dx_reg - IDX_W'(1));
                    end
                end
                else
                begin
                    ram_req.wdata = val_reg;
                    cnt_next      = CNT_W'(cnt_reg + CNT_W'(1));
                    status_next   = STAT_INSERTED;
                    state_next    = SEQ_FIN;
                end
            end

            SEQ_INS_LAST:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = val_reg;
                head_next     = val_reg;
                cnt_next      = CNT_W'(cnt_reg + CNT_W'(1));
                status_next   = STAT_INSERTED;
                state_next    = SEQ_FIN;
            end

            SEQ_REM:
            begin
                if (!last_idx)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = IDX_W'(dx_reg + IDX_W'(1));
                    dx_next       = IDX_W'(dx_reg + IDX_W'(1));
                end
                if (found_reg)
                begin
                    // close the gap: move entry down by one
                    ram_req.we    = 1'b1;
                    ram_req.waddr = IDX_W'(dx_reg - IDX_W'(1));
                    ram_req.wdata = ram_rdata;
                    if (dx_reg == IDX_W'(1))
                    begin
                        head_next = ram_rdata;
                    end
                end
                else if (ram_rdata == val_reg)
                begin
                    found_next = 1'b1;
                end
                if (last_idx)
                begin
                    if (found_reg || (ram_rdata == val_reg))
                    begin
                        cnt_next    = CNT_W'(cnt_reg - CNT_W'(1));
                        status_next = STAT_REMOVED;
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                    state_next = SEQ_FIN;
                end
            end

            SEQ_FIN:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status         = status_reg;
        res.entry_count    = 7'(cnt_reg);
        res.smallest_value = (cnt_reg == '0) ? 32'd0 : 32'(head_reg);
    end

endmodule : sti_seq
`default_nettype wire
